// File: src/aavr_pkg.sv
// Package for the axis-angle vector rotate block: fixed-point formats,
// CORDIC constants and the arctangent table. No dependencies.
`default_nettype none
package aavr_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int ANG_FRAC      = 30;
  localparam int CORDIC_STEPS  = 30;
  // CORDIC datapath widths: x/y hold Q30 values, z holds the folded angle
  localparam int XW = 33;
  localparam int ZW = 34;
  localparam int AW = 16;

  localparam logic signed [ZW-1:0] ANG_PI      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [XW-1:0] GAIN_INIT   = 33'sd652032874;

  typedef logic signed [AW-1:0] comp_t;
  typedef comp_t vec3_t [3];

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = ZW'(64'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/axis_angle_vector_rotate.sv
// Top level of the axis-angle vector rotate block (Rodrigues matrix).
// Depends on aavr_pkg for formats, CORDIC constants and the atan table.
//
// Usage: one input beat carries an angle (Q3.13 rad), a unit axis and a
// vector (FRAC_BITS fraction bits). One output beat carries the rotated
// vector, rounded and saturated to 16 bits. No state between items.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// Pipeline: 36 register stages (31 for the angle fold plus one CORDIC
// iteration per stage, then five for the matrix build, multiply, sum and
// saturate). Throughput: one item per cycle while out_ready stays high.
// Every stage carries its own valid bit and advances when it is empty or
// the stage after it advances, so bubbles close up and a stalled receiver
// backs up the pipeline without losing or repeating beats; in_ready drops
// only once every stage holds an item.
// Reset (rst_n low, synchronous) clears all valid bits; no item is in flight
// afterward and out_valid is low.
`default_nettype none
module axis_angle_vector_rotate #(
  parameter int FRAC_BITS = aavr_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  aavr_pkg::comp_t in_angle,
  input  wire  aavr_pkg::comp_t in_axis_x,
  input  wire  aavr_pkg::comp_t in_axis_y,
  input  wire  aavr_pkg::comp_t in_axis_z,
  input  wire  aavr_pkg::comp_t in_vec_x,
  input  wire  aavr_pkg::comp_t in_vec_y,
  input  wire  aavr_pkg::comp_t in_vec_z,
  output logic                out_valid,
  input  wire                 out_ready,
  output aavr_pkg::comp_t     out_rot_x,
  output aavr_pkg::comp_t     out_rot_y,
  output aavr_pkg::comp_t     out_rot_z
);
  import aavr_pkg::*;

  localparam int NC  = CORDIC_STEPS + 1;   // fold stage plus one per iteration
  localparam int SA  = NC;                 // cos/sin/t and axis products
  localparam int SB  = NC + 1;             // t*aa and axis*sin
  localparam int SC  = NC + 2;             // matrix terms
  localparam int SD  = NC + 3;             // matrix times vector
  localparam int SE  = NC + 4;             // row sum, round, saturate
  localparam int NST = NC + 5;

  localparam int TW  = XW;                 // t = 2^30 - cos
  localparam int AAW = 2 * AW;             // axis product
  localparam int PW  = TW + AAW;           // t * ai * aj
  localparam int QW  = AW + XW;            // ak * sin
  localparam int PRW = PW - 2 * FRAC_BITS + 1;
  localparam int QRW = QW - FRAC_BITS + 1;
  localparam int MW0 = (PRW > QRW) ? PRW : QRW;
  localparam int MW  = ((MW0 > XW) ? MW0 : XW) + 2;
  localparam int RW  = MW + AW;            // one matrix-vector product
  localparam int SW  = RW + 2;             // sum of three products

  localparam logic signed [TW-1:0] ONE_Q30 = TW'(64'sd1 <<< ANG_FRAC);

  // Pipeline control: each stage advances when empty or when the next one does
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;

  assign en[NST-1] = !vld_r[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end
  assign in_ready  = en[0];
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // CORDIC stage registers
  logic signed [XW-1:0] x_r [NC];
  logic signed [XW-1:0] y_r [NC];
  logic signed [ZW-1:0] z_r [NC];
  logic                 flip_r [NC];
  vec3_t                ax_r [NC];
  vec3_t                v_r  [NC];

  // Widen the angle to Q30 and fold it into -pi/2..pi/2
  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_fold_nxt;
  logic                 flip_nxt;

  always_comb begin
    z_in = ZW'(in_angle) <<< (ANG_FRAC - 13);
    z_fold_nxt = z_in;
    flip_nxt = 1'b0;
    if (z_in > ANG_HALF_PI) begin
      z_fold_nxt = z_in - ANG_PI;
      flip_nxt = 1'b1;
    end else if (z_in < -ANG_HALF_PI) begin
      z_fold_nxt = z_in + ANG_PI;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]    <= GAIN_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= z_fold_nxt;
      flip_r[0] <= flip_nxt;
      ax_r[0]   <= '{in_axis_x, in_axis_y, in_axis_z};
      v_r[0]    <= '{in_vec_x, in_vec_y, in_vec_z};
    end
  end

  // One rotation step per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_lut(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_lut(i);
        end
        flip_r[i+1] <= flip_r[i];
        ax_r[i+1]   <= ax_r[i];
        v_r[i+1]    <= v_r[i];
      end
    end
  end

  // Stage A: undo the fold, form t and the axis outer products
  logic signed [XW-1:0]  c_a_r, s_a_r;
  logic signed [TW-1:0]  t_a_r;
  logic signed [AAW-1:0] aa_a_r [9];
  vec3_t                 ax_a_r, v_a_r;
  logic signed [XW-1:0]  c_fin, s_fin;

  always_comb begin
    c_fin = flip_r[NC-1] ? -x_r[NC-1] : x_r[NC-1];
    s_fin = flip_r[NC-1] ? -y_r[NC-1] : y_r[NC-1];
  end

  always_ff @(posedge clk) begin
    if (en[SA]) begin
      c_a_r  <= c_fin;
      s_a_r  <= s_fin;
      t_a_r  <= ONE_Q30 - TW'(c_fin);
      for (int k = 0; k < 9; k++) begin
        aa_a_r[k] <= AAW'(ax_r[NC-1][k/3]) * AAW'(ax_r[NC-1][k%3]);
      end
      ax_a_r <= ax_r[NC-1];
      v_a_r  <= v_r[NC-1];
    end
  end

  // Stage B: scale by t and by sin
  logic signed [PW-1:0] p_b_r [9];
  logic signed [QW-1:0] q_b_r [3];
  logic signed [XW-1:0] c_b_r;
  vec3_t                v_b_r;

  always_ff @(posedge clk) begin
    if (en[SB]) begin
      for (int k = 0; k < 9; k++) p_b_r[k] <= PW'(t_a_r) * PW'(aa_a_r[k]);
      for (int k = 0; k < 3; k++) q_b_r[k] <= QW'(ax_a_r[k]) * QW'(s_a_r);
      c_b_r <= c_a_r;
      v_b_r <= v_a_r;
    end
  end

  // Stage C: round and combine into the nine matrix terms
  logic signed [PW-1:0] p_rnd [9];
  logic signed [QW-1:0] q_rnd [3];
  logic signed [MW-1:0] m_nxt [9];
  logic signed [MW-1:0] m_r   [9];
  vec3_t                v_c_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      p_rnd[k] = (p_b_r[k] + (PW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      m_nxt[k] = MW'(p_rnd[k]);
    end
    for (int k = 0; k < 3; k++) begin
      q_rnd[k] = (q_b_r[k] + (QW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
    m_nxt[0] = m_nxt[0] + MW'(c_b_r);
    m_nxt[4] = m_nxt[4] + MW'(c_b_r);
    m_nxt[8] = m_nxt[8] + MW'(c_b_r);
    m_nxt[1] = m_nxt[1] - MW'(q_rnd[2]);
    m_nxt[3] = m_nxt[3] + MW'(q_rnd[2]);
    m_nxt[2] = m_nxt[2] + MW'(q_rnd[1]);
    m_nxt[6] = m_nxt[6] - MW'(q_rnd[1]);
    m_nxt[5] = m_nxt[5] - MW'(q_rnd[0]);
    m_nxt[7] = m_nxt[7] + MW'(q_rnd[0]);
  end

  always_ff @(posedge clk) begin
    if (en[SC]) begin
      m_r   <= m_nxt;
      v_c_r <= v_b_r;
    end
  end

  // Stage D: multiply each term by its vector component
  logic signed [RW-1:0] pr_r [9];

  always_ff @(posedge clk) begin
    if (en[SD]) begin
      for (int k = 0; k < 9; k++) pr_r[k] <= RW'(m_r[k]) * RW'(v_c_r[k%3]);
    end
  end

  // Stage E: sum rows, round out of Q30 and saturate
  logic signed [SW-1:0] acc [3];
  logic signed [SW-1:0] acc_rnd [3];
  comp_t                rot_nxt [3];
  comp_t                rot_r   [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = SW'(pr_r[3*r]) + SW'(pr_r[3*r+1]) + SW'(pr_r[3*r+2]);
      acc_rnd[r] = (acc[r] + (SW'(1) <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
      if (acc_rnd[r] > SW'(32767))       rot_nxt[r] = 16'sh7fff;
      else if (acc_rnd[r] < -SW'(32768)) rot_nxt[r] = -16'sh8000;
      else                               rot_nxt[r] = AW'(acc_rnd[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[SE]) rot_r <= rot_nxt;
  end

  assign out_rot_x = rot_r[0];
  assign out_rot_y = rot_r[1];
  assign out_rot_z = rot_r[2];

  // Checks
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ready)
    else $error("input stalled with empty first stage");
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat not captured");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SD] && !en[SE] |=> vld_r[SD])
    else $error("beat dropped behind stalled output");

endmodule
`default_nettype wire

// File: tb/tb_axis_angle_vector_rotate.sv
// Testbench for axis_angle_vector_rotate: drives angle/axis/vector beats, predicts
// the rotated vector with a bit-exact CORDIC + Rodrigues model, checks every result.
// Depends on aavr_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_axis_angle_vector_rotate;
  import aavr_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] vx, vy, vz;
  } rot_req_t;

  typedef struct packed {
    logic signed [15:0] rx, ry, rz;
  } rot_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  comp_t in_angle = '0, in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  comp_t in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  comp_t out_rot_x, out_rot_y, out_rot_z;

  rot_vec_t rotated_q[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_cnt = 0;
  bit stall_enable = 1'b1;

  always #2 clk = ~clk;

  axis_angle_vector_rotate u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_angle(in_angle), .in_axis_x(in_axis_x), .in_axis_y(in_axis_y),
    .in_axis_z(in_axis_z), .in_vec_x(in_vec_x), .in_vec_y(in_vec_y),
    .in_vec_z(in_vec_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z)
  );

  // Round half up by s bits
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // Predict the rotated vector for one request
  function automatic rot_vec_t rotate_vector(rot_req_t r);
    longint z, x, y, nx, c, s, t, acc;
    longint a[3], v[3], m[3][3], sk[3];
    longint atan_v;
    bit flip;
    rot_vec_t res;
    z = longint'(r.angle) * (64'sd1 <<< 17);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      atan_v = (i < 10) ? longint'(atan_lut(i)) : (64'sd1 <<< (30 - i));
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_v;
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_v;
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x; s = y;
    t = (64'sd1 <<< 30) - c;
    a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
    v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
    for (int i = 0; i < 3; i++) begin
      sk[i] = rnd_shift(a[i] * s, FB);
      for (int j = 0; j < 3; j++) m[i][j] = rnd_shift(t * a[i] * a[j], 2 * FB);
      m[i][i] += c;
    end
    m[0][1] -= sk[2]; m[1][0] += sk[2];
    m[0][2] += sk[1]; m[2][0] -= sk[1];
    m[1][2] -= sk[0]; m[2][1] += sk[0];
    acc = m[0][0] * v[0] + m[0][1] * v[1] + m[0][2] * v[2];
    res.rx = sat16(rnd_shift(acc, 30));
    acc = m[1][0] * v[0] + m[1][1] * v[1] + m[1][2] * v[2];
    res.ry = sat16(rnd_shift(acc, 30));
    acc = m[2][0] * v[0] + m[2][1] * v[1] + m[2][2] * v[2];
    res.rz = sat16(rnd_shift(acc, 30));
    return res;
  endfunction

  // Send one beat, with an optional random gap ahead of it
  task automatic send_rotation(rot_req_t r);
    int gap;
    if (stall_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= r.angle;
    in_axis_x <= r.ax; in_axis_y <= r.ay; in_axis_z <= r.az;
    in_vec_x <= r.vx; in_vec_y <= r.vy; in_vec_z <= r.vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotated_q.push_back(rotate_vector(r));
    beats_in++;
    @(negedge clk);
  endtask

  task automatic send_fields(int ang, int ax, int ay, int az, int vx, int vy, int vz);
    rot_req_t r;
    r.angle = ang[15:0]; r.ax = ax[15:0]; r.ay = ay[15:0]; r.az = az[15:0];
    r.vx = vx[15:0]; r.vy = vy[15:0]; r.vz = vz[15:0];
    send_rotation(r);
  endtask

  function automatic int rand_s16();
    return int'($signed(16'($urandom())));
  endfunction

  function automatic int rand_axis();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Field extremes, principal axes, half-pi fold edges
  task automatic test_directed();
    send_fields(0, 16384, 0, 0, 16384, 16384, 16384);
    send_fields(12868, 0, 0, 16384, 16384, 0, 0);
    send_fields(-12868, 0, 0, 16384, 16384, 0, 0);
    send_fields(25736, 16384, 0, 0, 0, 16384, -16384);
    send_fields(-25736, 0, 16384, 0, 16384, 0, 16384);
    send_fields(12867, 0, -16384, 0, 1000, -2000, 3000);
    send_fields(12869, -16384, 0, 0, 1000, -2000, 3000);
    send_fields(-12869, 0, 0, -16384, 1000, -2000, 3000);
    send_fields(6434, 9459, 9459, 9459, 32767, 32767, 32767);
    send_fields(-6434, 9459, -9459, 9459, -32768, -32768, -32768);
    send_fields(32767, 16384, 16384, 16384, 32767, -32768, 32767);
    send_fields(-32768, -16384, -16384, -16384, -32768, 32767, -32768);
    send_fields(3000, 16384, 16384, 0, 32767, 32767, 0);
    send_fields(-3000, -16384, 16384, -16384, -32768, 32767, 32767);
    send_fields(0, 0, 0, 0, 32767, -32768, 1);
    send_fields(20000, 0, 0, 0, -1, -1, -1);
    send_fields(1, 32767, -32768, 32767, 12345, -12345, 0);
    send_fields(-1, -32768, 32767, -32768, -32768, -32768, 32767);
  endtask

  // Mostly in-range angles and axes, some full-range noise
  task automatic test_random(int count);
    rot_req_t r;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        r.angle = rand_s16(); r.ax = rand_s16(); r.ay = rand_s16(); r.az = rand_s16();
      end else begin
        r.angle = $urandom_range(0, 51472) - 25736;
        r.ax = rand_axis(); r.ay = rand_axis(); r.az = rand_axis();
      end
      if ($urandom_range(0, 1)) begin
        r.vx = rand_s16(); r.vy = rand_s16(); r.vz = rand_s16();
      end else begin
        r.vx = rand_axis(); r.vy = rand_axis(); r.vz = rand_axis();
      end
      send_rotation(r);
    end
  endtask

  // Receiver stalls in random bursts
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_enable && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin
    rot_vec_t exp_v;
    if (rst_n && (out_valid && out_ready || in_valid && in_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (rotated_q.size() == 0) begin
        $error("result beat with no prediction pending");
        errors++;
      end else begin
        exp_v = rotated_q.pop_front();
        if (out_rot_x !== exp_v.rx) begin
          $error("rot_x expected %0d actual %0d", exp_v.rx, out_rot_x); errors++;
        end
        if (out_rot_y !== exp_v.ry) begin
          $error("rot_y expected %0d actual %0d", exp_v.ry, out_rot_y); errors++;
        end
        if (out_rot_z !== exp_v.rz) begin
          $error("rot_z expected %0d actual %0d", exp_v.rz, out_rot_z); errors++;
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("axis_angle_vector_rotate verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(800);
    stall_enable = 1'b0;
    test_random(200);
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (rotated_q.size() != 0) begin
      $error("%0d predictions left over", rotated_q.size());
      errors++;
    end
    $display("Sent %0d rotation beats, checked %0d results, %0d mismatches.",
             beats_in, beats_out, errors);
    if (errors == 0) $display("axis_angle_vector_rotate verification clean");
    else $display("axis_angle_vector_rotate verification failed");
    $finish;
  end
endmodule
